@@ rtl/char_lcd_nibble_interface_unit_assert.svh @@
// assertion macros for the character lcd nibble interface checker
`ifndef CHAR_LCD_NIBBLE_INTERFACE_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define CLCD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CLCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/clcd_pkg.sv @@
// shared types, constants and microcode program for the lcd nibble interface
`default_nettype none

package clcd_pkg;

   // default timing parameters
   localparam int CLK_PER_US_DEF      = 50;
   localparam int ENABLE_PULSE_US_DEF = 1;
   localparam int NIBBLE_HOLD_US_DEF  = 50;
   localparam int CLEAR_WAIT_US_DEF   = 2000;

   // fixed power-up gaps
   localparam int POWER_UP_WAIT_US = 50000;
   localparam int FIRST_GAP_US     = 5000;
   localparam int SECOND_GAP_US    = 110;

   localparam int US_W     = 16;
   localparam int AFTER_W  = 13;
   localparam int STEP_W   = 5;

   // request kinds
   localparam logic [1:0] REQ_INIT   = 2'd0;
   localparam logic [1:0] REQ_CMD    = 2'd1;
   localparam logic [1:0] REQ_CHAR   = 2'd2;
   localparam logic [1:0] REQ_CURSOR = 2'd3;

   // lcd command bytes and nibbles
   localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
   localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_ENTRY     = 8'h06;
   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
   localparam logic [7:0] ROW1_BASE     = 8'h40;
   localparam logic [3:0] WAKE_NIB      = 4'h3;
   localparam logic [3:0] FOUR_BIT_NIB  = 4'h2;

   // nibble source
   localparam logic [1:0] NIB_CONST = 2'd0;
   localparam logic [1:0] NIB_HI    = 2'd1;
   localparam logic [1:0] NIB_LO    = 2'd2;

   // byte source
   localparam logic BYTE_VALUE = 1'b0;
   localparam logic BYTE_ADDR  = 1'b1;

   // extra hold selection
   localparam logic [1:0] EXT_NONE   = 2'd0;
   localparam logic [1:0] EXT_FIRST  = 2'd1;
   localparam logic [1:0] EXT_SECOND = 2'd2;
   localparam logic [1:0] EXT_CLEAR  = 2'd3;

   // program entry points
   localparam logic [STEP_W-1:0] ENT_INIT   = 5'd0;
   localparam logic [STEP_W-1:0] ENT_CMD    = 5'd12;
   localparam logic [STEP_W-1:0] ENT_CMD_CLR = 5'd14;
   localparam logic [STEP_W-1:0] ENT_CHAR   = 5'd15;
   localparam logic [STEP_W-1:0] ENT_CURSOR = 5'd17;

   typedef struct packed {
      logic [1:0]        nib_sel;
      logic [3:0]        nib_const;
      logic              byte_sel;
      logic              rs;
      logic              pre;
      logic [1:0]        ext_sel;
      logic              jmp_clear;
      logic [STEP_W-1:0] target;
      logic              last;
   } ucode_type;

   typedef struct packed {
      logic      capture;
      logic      emit;
      ucode_type uword;
   } dp_ctrl_type;

   typedef struct packed {
      logic               value_clear;
      logic [US_W-1:0]    before_us;
      logic [AFTER_W-1:0] after_us;
   } dp_stat_type;

   function automatic ucode_type uw(
      input logic [1:0]        nib_sel,
      input logic [3:0]        nib_const,
      input logic              byte_sel,
      input logic              rs,
      input logic              pre,
      input logic [1:0]        ext_sel,
      input logic              jmp_clear,
      input logic [STEP_W-1:0] target,
      input logic              last
   );
      ucode_type w;
      w.nib_sel   = nib_sel;
      w.nib_const = nib_const;
      w.byte_sel  = byte_sel;
      w.rs        = rs;
      w.pre       = pre;
      w.ext_sel   = ext_sel;
      w.jmp_clear = jmp_clear;
      w.target    = target;
      w.last      = last;
      return w;
   endfunction

   // control store: one word per nibble strobe
   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         5'd0:  w = uw(NIB_CONST, WAKE_NIB, BYTE_VALUE, 1'b0, 1'b1, EXT_FIRST,
                       1'b0, ENT_INIT, 1'b0);
         5'd1:  w = uw(NIB_CONST, WAKE_NIB, BYTE_VALUE, 1'b0, 1'b0, EXT_SECOND,
                       1'b0, ENT_INIT, 1'b0);
         5'd2:  w = uw(NIB_CONST, WAKE_NIB, BYTE_VALUE, 1'b0, 1'b0, EXT_SECOND,
                       1'b0, ENT_INIT, 1'b0);
         5'd3:  w = uw(NIB_CONST, FOUR_BIT_NIB, BYTE_VALUE, 1'b0, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b0);
         5'd4:  w = uw(NIB_CONST, CMD_FUNC_SET[7:4], BYTE_VALUE, 1'b0, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b0);
         5'd5:  w = uw(NIB_CONST, CMD_FUNC_SET[3:0], BYTE_VALUE, 1'b0, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b0);
         5'd6:  w = uw(NIB_CONST, CMD_DISP_ON[7:4], BYTE_VALUE, 1'b0, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b0);
         5'd7:  w = uw(NIB_CONST, CMD_DISP_ON[3:0], BYTE_VALUE, 1'b0, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b0);
         5'd8:  w = uw(NIB_CONST, CMD_CLEAR[7:4], BYTE_VALUE, 1'b0, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b0);
         5'd9:  w = uw(NIB_CONST, CMD_CLEAR[3:0], BYTE_VALUE, 1'b0, 1'b0, EXT_CLEAR,
                       1'b0, ENT_INIT, 1'b0);
         5'd10: w = uw(NIB_CONST, CMD_ENTRY[7:4], BYTE_VALUE, 1'b0, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b0);
         5'd11: w = uw(NIB_CONST, CMD_ENTRY[3:0], BYTE_VALUE, 1'b0, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b1);
         // command byte, branch to the clear variant of the low nibble
         5'd12: w = uw(NIB_HI, 4'h0, BYTE_VALUE, 1'b0, 1'b0, EXT_NONE,
                       1'b1, ENT_CMD_CLR, 1'b0);
         5'd13: w = uw(NIB_LO, 4'h0, BYTE_VALUE, 1'b0, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b1);
         5'd14: w = uw(NIB_LO, 4'h0, BYTE_VALUE, 1'b0, 1'b0, EXT_CLEAR,
                       1'b0, ENT_INIT, 1'b1);
         5'd15: w = uw(NIB_HI, 4'h0, BYTE_VALUE, 1'b1, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b0);
         5'd16: w = uw(NIB_LO, 4'h0, BYTE_VALUE, 1'b1, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b1);
         5'd17: w = uw(NIB_HI, 4'h0, BYTE_ADDR, 1'b0, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b0);
         5'd18: w = uw(NIB_LO, 4'h0, BYTE_ADDR, 1'b0, 1'b0, EXT_NONE,
                       1'b0, ENT_INIT, 1'b1);
         default: w = uw(NIB_CONST, 4'h0, BYTE_VALUE, 1'b0, 1'b0, EXT_NONE,
                         1'b0, ENT_INIT, 1'b1);
      endcase
      return w;
   endfunction

   function automatic logic [STEP_W-1:0] entry(input logic [1:0] req_type);
      logic [STEP_W-1:0] e;
      unique case (req_type)
         REQ_INIT:   e = ENT_INIT;
         REQ_CMD:    e = ENT_CMD;
         REQ_CHAR:   e = ENT_CHAR;
         REQ_CURSOR: e = ENT_CURSOR;
         default:    e = ENT_INIT;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

@@ rtl/char_lcd_nibble_interface_unit.sv @@
// top level of the character lcd 4-bit nibble interface
//
// channel      | ports                                      | handshake
// -------------+--------------------------------------------+----------------------
// request      | req_type req_value req_column req_row      | start high, busy low
// result       | rsp_reg_select rsp_nibble rsp_wait_*_us    | rsp_valid, one cycle
//              | rsp_last                                   |
//
// each nibble strobe is timed in real time: wait_before_us, then
// ENABLE_PULSE_US of enable, then wait_after_us, each counted by one
// microsecond timer
// a byte request is two strobes;
// init is twelve strobes and is dominated by its 50 ms power-up wait
// busy rises after the accepting edge and falls at the edge that ends the last strobe
// synchronous reset returns the sequencer to idle and drops rsp_valid
// the receiver cannot stall: every result appears for exactly one cycle
`default_nettype none

module char_lcd_nibble_interface_unit #(
   parameter int CLK_PER_US      = clcd_pkg::CLK_PER_US_DEF,
   parameter int ENABLE_PULSE_US = clcd_pkg::ENABLE_PULSE_US_DEF,
   parameter int NIBBLE_HOLD_US  = clcd_pkg::NIBBLE_HOLD_US_DEF,
   parameter int CLEAR_WAIT_US   = clcd_pkg::CLEAR_WAIT_US_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_type,
   input  wire logic [7:0]                   req_value,
   input  wire logic [5:0]                   req_column,
   input  wire logic                         req_row,
   // result channel
   output logic                              rsp_valid,
   output logic                              rsp_reg_select,
   output logic [3:0]                        rsp_nibble,
   output logic [clcd_pkg::US_W-1:0]         rsp_wait_before_us,
   output logic [clcd_pkg::AFTER_W-1:0]      rsp_wait_after_us,
   output logic                              rsp_last
);

   // control word and strobes from the sequencer to the datapath
   clcd_pkg::dp_ctrl_type ctrl;
   // clear detect and wait values back to the sequencer
   clcd_pkg::dp_stat_type stat;

   logic                      tmr_load;
   logic [clcd_pkg::US_W-1:0] tmr_us;
   logic                      tmr_done;

   // microcode sequencer: step counter, control store, jump on clear command
   clcd_seq #(
      .ENABLE_PULSE_US (ENABLE_PULSE_US)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .busy     (busy),
      .stat     (stat),
      .ctrl     (ctrl),
      .tmr_load (tmr_load),
      .tmr_us   (tmr_us),
      .tmr_done (tmr_done)
   );

   // one shared microsecond timer serves every wait phase
   clcd_timer #(
      .CLK_PER_US (CLK_PER_US)
   ) u_timer (
      .clock   (clock),
      .reset   (reset),
      .load    (tmr_load),
      .load_us (tmr_us),
      .done    (tmr_done)
   );

   // datapath: request capture, nibble select, result registers
   clcd_dpath #(
      .NIBBLE_HOLD_US (NIBBLE_HOLD_US),
      .CLEAR_WAIT_US  (CLEAR_WAIT_US)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_value          (req_value),
      .req_column         (req_column),
      .req_row            (req_row),
      .ctrl               (ctrl),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_reg_select     (rsp_reg_select),
      .rsp_nibble         (rsp_nibble),
      .rsp_wait_before_us (rsp_wait_before_us),
      .rsp_wait_after_us  (rsp_wait_after_us),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

@@ rtl/clcd_timer.sv @@
// microsecond down-counter with a clock prescaler
`default_nettype none

module clcd_timer #(
   parameter int CLK_PER_US = clcd_pkg::CLK_PER_US_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load,
   input  wire logic [clcd_pkg::US_W-1:0] load_us,
   output logic                           done
);

   localparam int PW = (CLK_PER_US > 1) ? $clog2(CLK_PER_US) : 1;
   localparam logic [PW-1:0] PRE_LAST = PW'(CLK_PER_US - 1);

   logic [PW-1:0]             pre_ff, pre_in;
   logic [clcd_pkg::US_W-1:0] us_ff, us_in;

   always_comb begin
      pre_in = pre_ff;
      us_in  = us_ff;
      if (load) begin
         pre_in = '0;
         us_in  = load_us;
      end else if (us_ff != '0) begin
         if (pre_ff == PRE_LAST) begin
            pre_in = '0;
            us_in  = us_ff - 1'b1;
         end else begin
            pre_in = pre_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff <= '0;
         us_ff  <= '0;
      end else begin
         pre_ff <= pre_in;
         us_ff  <= us_in;
      end
   end

   assign done = (us_ff == '0);

endmodule

`default_nettype wire

@@ rtl/clcd_seq.sv @@
// step counter, control word fetch and phase sequencing
`default_nettype none

module clcd_seq #(
   parameter int ENABLE_PULSE_US = clcd_pkg::ENABLE_PULSE_US_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [1:0]                req_type,
   output logic                           busy,
   input  wire clcd_pkg::dp_stat_type     stat,
   output clcd_pkg::dp_ctrl_type          ctrl,
   output logic                           tmr_load,
   output logic [clcd_pkg::US_W-1:0]      tmr_us,
   input  wire logic                      tmr_done
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_PRE   = 3'd2;
   localparam logic [2:0] ST_PULSE = 3'd3;
   localparam logic [2:0] ST_HOLD  = 3'd4;
   localparam logic [2:0] ST_NEXT  = 3'd5;

   localparam logic [clcd_pkg::US_W-1:0] PULSE_US = clcd_pkg::US_W'(ENABLE_PULSE_US);

   logic [2:0]                  state_ff, state_in;
   logic [clcd_pkg::STEP_W-1:0] step_ff, step_in;
   clcd_pkg::ucode_type         uword;

   assign uword = clcd_pkg::ucode(step_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      tmr_load     = 1'b0;
      tmr_us       = '0;
      ctrl.capture = 1'b0;
      ctrl.emit    = 1'b0;
      ctrl.uword   = uword;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.capture = 1'b1;
               step_in      = clcd_pkg::entry(req_type);
               state_in     = ST_LOAD;
            end
         end
         ST_LOAD: begin
            tmr_load = 1'b1;
            tmr_us   = stat.before_us;
            state_in = ST_PRE;
         end
         ST_PRE: begin
            if (tmr_done) begin
               tmr_load = 1'b1;
               tmr_us   = PULSE_US;
               state_in = ST_PULSE;
            end
         end
         ST_PULSE: begin
            if (tmr_done) begin
               tmr_load = 1'b1;
               tmr_us   = clcd_pkg::US_W'(stat.after_us);
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (tmr_done) begin
               ctrl.emit = 1'b1;
               state_in  = ST_NEXT;
            end
         end
         ST_NEXT: begin
            priority if (uword.last) begin
               state_in = ST_IDLE;
            end else if (uword.jmp_clear && stat.value_clear) begin
               step_in  = uword.target;
               state_in = ST_LOAD;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/clcd_dpath.sv @@
// request registers, nibble and wait selection, result registers
`default_nettype none

module clcd_dpath #(
   parameter int NIBBLE_HOLD_US = clcd_pkg::NIBBLE_HOLD_US_DEF,
   parameter int CLEAR_WAIT_US  = clcd_pkg::CLEAR_WAIT_US_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [7:0]                   req_value,
   input  wire logic [5:0]                   req_column,
   input  wire logic                         req_row,
   input  wire clcd_pkg::dp_ctrl_type        ctrl,
   output clcd_pkg::dp_stat_type             stat,
   output logic                              rsp_valid,
   output logic                              rsp_reg_select,
   output logic [3:0]                        rsp_nibble,
   output logic [clcd_pkg::US_W-1:0]         rsp_wait_before_us,
   output logic [clcd_pkg::AFTER_W-1:0]      rsp_wait_after_us,
   output logic                              rsp_last
);

   localparam int AW = clcd_pkg::AFTER_W;
   localparam logic [AW-1:0] HOLD_W   = AW'(NIBBLE_HOLD_US);
   localparam logic [AW-1:0] CLEAR_W  = AW'(CLEAR_WAIT_US);
   localparam logic [AW-1:0] FIRST_W  = AW'(clcd_pkg::FIRST_GAP_US);
   localparam logic [AW-1:0] SECOND_W = AW'(clcd_pkg::SECOND_GAP_US);
   localparam logic [clcd_pkg::US_W-1:0] POWER_W =
      clcd_pkg::US_W'(clcd_pkg::POWER_UP_WAIT_US);

   logic [7:0]    value_ff, addr_ff, addr_in;
   logic [7:0]    byte_sel;
   logic [3:0]    nib;
   logic [AW-1:0] extra;

   logic                         valid_ff;
   logic                         rs_ff;
   logic [3:0]                   nib_ff;
   logic [clcd_pkg::US_W-1:0]    before_ff;
   logic [AW-1:0]                after_ff;
   logic                         last_ff;

   // ddram address command, row 1 starts at 0x40
   always_comb begin
      if (req_row) begin
         addr_in = clcd_pkg::CMD_SET_DDRAM | (clcd_pkg::ROW1_BASE + {2'b00, req_column});
      end else begin
         addr_in = clcd_pkg::CMD_SET_DDRAM | {2'b00, req_column};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         value_ff <= req_value;
         addr_ff  <= addr_in;
      end
   end

   assign byte_sel = (ctrl.uword.byte_sel == clcd_pkg::BYTE_ADDR) ? addr_ff : value_ff;

   always_comb begin
      unique case (ctrl.uword.nib_sel)
         clcd_pkg::NIB_HI: nib = byte_sel[7:4];
         clcd_pkg::NIB_LO: nib = byte_sel[3:0];
         default:          nib = ctrl.uword.nib_const;
      endcase
   end

   always_comb begin
      unique case (ctrl.uword.ext_sel)
         clcd_pkg::EXT_FIRST:  extra = FIRST_W;
         clcd_pkg::EXT_SECOND: extra = SECOND_W;
         clcd_pkg::EXT_CLEAR:  extra = CLEAR_W;
         default:              extra = '0;
      endcase
   end

   assign stat.value_clear = (value_ff == clcd_pkg::CMD_CLEAR);
   assign stat.before_us   = ctrl.uword.pre ? POWER_W : '0;
   assign stat.after_us    = HOLD_W + extra;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rs_ff     <= ctrl.uword.rs;
         nib_ff    <= nib;
         before_ff <= stat.before_us;
         after_ff  <= stat.after_us;
         last_ff   <= ctrl.uword.last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_reg_select     = rs_ff;
   assign rsp_nibble         = nib_ff;
   assign rsp_wait_before_us = before_ff;
   assign rsp_wait_after_us  = after_ff;
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

@@ rtl/clcd_checker.sv @@
// port-level checker for the lcd nibble interface, bound to the top level
`default_nettype none

`include "char_lcd_nibble_interface_unit_assert.svh"

module clcd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_last
);

   `CLCD_ASSERT_NOW(a_rsp_in_busy, rsp_valid, busy, "result strobe outside a transaction")
   `CLCD_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
   `CLCD_ASSERT_NEXT(a_last_idle, rsp_valid && rsp_last, !busy, "busy held after last strobe")
   `CLCD_ASSERT_NEXT(a_strobe_gap, rsp_valid, !rsp_valid, "result strobes back to back")

endmodule

bind char_lcd_nibble_interface_unit clcd_checker u_checker (.*);

`default_nettype wire
